### rtl/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, constants and CORDIC angle table for the box bounds block.
// ----------------------------------------------------------------------------
`default_nettype none
package obb_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int ITERS      = 30;
	localparam int CW         = 34;
	localparam int ZW         = 33;
	localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam logic [1:0] REG_RADIUS = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic        circle;
		logic [1:0]  quad;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [32:0] left;
		logic signed [32:0] right;
		logic signed [32:0] bottom;
		logic signed [32:0] top;
		logic [30:0] radius;
	} side_t;

	typedef struct packed {
		logic signed [31:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
		logic signed [31:0] min_x, min_y, max_x, max_y;
	} result_t;

	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic [31:0] v;
		unique case (i)
			0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
			3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
			15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
			21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
			24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
			27: v = 32'h00000005; 28: v = 32'h00000003; default: v = 32'h00000001;
		endcase
		return $signed({1'b0, v});
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -36'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

### rtl/obb_if.sv
// ----------------------------------------------------------------------------
// obb_if
// Valid/ready channel interfaces for input, result and register write beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface obb_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0] angle;
	modport source(output valid, pos_x, pos_y, angle, input ready);
	modport sink(input valid, pos_x, pos_y, angle, output ready);
endinterface

interface obb_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] corner0_x, corner0_y, corner1_x, corner1_y;
	logic signed [31:0] corner2_x, corner2_y, corner3_x, corner3_y;
	logic signed [31:0] min_x, min_y, max_x, max_y;
	modport source(output valid, corner0_x, corner0_y, corner1_x, corner1_y,
		corner2_x, corner2_y, corner3_x, corner3_y, min_x, min_y, max_x, max_y,
		input ready);
	modport sink(input valid, corner0_x, corner0_y, corner1_x, corner1_y,
		corner2_x, corner2_y, corner3_x, corner3_y, min_x, min_y, max_x, max_y,
		output ready);
endinterface

interface obb_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/oriented_box_bounds_core.sv
// ----------------------------------------------------------------------------
// oriented_box_bounds_core
// Rotated box corners and axis-aligned bounds of a 2D body, Q16.16.
// ----------------------------------------------------------------------------
// One beat per cycle in, one per cycle out while the output is not stalled. The
// pipeline is one input register, 30 CORDIC cells (one iteration each) and three
// stages of multiply, round/saturate and min/max. The whole pipeline advances when the
// output register is empty or being taken, so a stall holds every stage.
`default_nettype none
module oriented_box_bounds_core import obb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	obb_in_if.sink   in_ch,
	obb_out_if.source out_ch,
	obb_cfg_if.sink  cfg
);
	localparam int LAT = ITERS + 4;

	logic        mode_q;
	logic [30:0] width_q, height_q, radius_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= 31'(1 << FRAC_BITS);
			height_q <= 31'(1 << FRAC_BITS);
			radius_q <= 31'(1 << FRAC_BITS);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODE:   mode_q   <= cfg.data[0];
				REG_WIDTH:  width_q  <= cfg.data[30:0];
				REG_HEIGHT: height_q <= cfg.data[30:0];
				REG_RADIUS: radius_q <= cfg.data[30:0];
			endcase
		end
	end

	logic [LAT-1:0] vld_q;
	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[LAT-1];

	// input stage
	logic [30:0] w, h;
	logic [31:0] phase;
	logic [1:0]  quad;
	logic signed [ZW-1:0] z0;
	side_t   sd0, sd_s1;
	cordic_t cd_s1;
	always_comb begin
		w = (width_q  < 31'(1 << FRAC_BITS)) ? 31'(1 << FRAC_BITS) : width_q;
		h = (height_q < 31'(1 << FRAC_BITS)) ? 31'(1 << FRAC_BITS) : height_q;
		phase = {in_ch.angle[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
		quad = 2'((phase + 32'h20000000) >> 30);
		z0 = $signed({1'b0, phase - {quad, 30'd0}});
		if (z0 >= 33'sh080000000) z0 = z0 - 33'sh100000000;
		sd0.circle = mode_q;
		sd0.quad   = quad;
		sd0.px     = in_ch.pos_x;
		sd0.py     = in_ch.pos_y;
		sd0.left   = -$signed({2'b0, w[30:1]});
		sd0.right  = sd0.left + $signed({2'b0, w});
		sd0.bottom = -$signed({2'b0, h[30:1]});
		sd0.top    = sd0.bottom + $signed({2'b0, h});
		sd0.radius = radius_q;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1 <= sd0;
			cd_s1 <= '{x: CORDIC_K, y: '0, z: z0};
		end
	end

	cordic_t cd [ITERS+1];
	side_t   sd [ITERS+1];
	assign cd[0] = cd_s1;
	assign sd[0] = sd_s1;
	for (genvar i = 0; i < ITERS; i++) begin : g_cell
		obb_cordic_cell u_cell (
			.clk(clk), .en(en), .step(5'(i)), .d(cd[i]), .sd(sd[i]), .q(cd[i+1]),
			.sq(sd[i+1])
		);
	end

	result_t res;
	obb_corner u_corner (.clk(clk), .en(en), .d(cd[ITERS]), .sd(sd[ITERS]), .q(res));

	assign out_ch.corner0_x = res.c0x; assign out_ch.corner0_y = res.c0y;
	assign out_ch.corner1_x = res.c1x; assign out_ch.corner1_y = res.c1y;
	assign out_ch.corner2_x = res.c2x; assign out_ch.corner2_y = res.c2y;
	assign out_ch.corner3_x = res.c3x; assign out_ch.corner3_y = res.c3y;
	assign out_ch.min_x = res.min_x; assign out_ch.min_y = res.min_y;
	assign out_ch.max_x = res.max_x; assign out_ch.max_y = res.max_y;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q)) else $error("pipeline moved while stalled");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready)) else $error("ready mismatch");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && res.min_x > res.max_x |-> 1'b0) else $error("bounds inverted");
endmodule
`default_nettype wire

### rtl/obb_cordic_cell.sv
// ----------------------------------------------------------------------------
// obb_cordic_cell
// One CORDIC rotation step with its side-band register; one cell per iteration.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_cordic_cell import obb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [4:0] step,
	input  wire cordic_t    d,
	input  wire side_t      sd,
	output cordic_t         q,
	output side_t           sq
);
	cordic_t n;
	always_comb begin
		if (!d.z[ZW-1]) begin
			n.x = d.x - (d.y >>> step);
			n.y = d.y + (d.x >>> step);
			n.z = d.z - atan_lut(int'(step));
		end else begin
			n.x = d.x + (d.y >>> step);
			n.y = d.y - (d.x >>> step);
			n.z = d.z + atan_lut(int'(step));
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q  <= n;
			sq <= sd;
		end
	end
endmodule
`default_nettype wire

### rtl/obb_corner.sv
// ----------------------------------------------------------------------------
// obb_corner
// Rotates and translates the four corners, then reduces to bounds (in circle
// mode, radius bounds). Three register stages, all advancing on en.
// ----------------------------------------------------------------------------
`default_nettype none
module obb_corner import obb_pkg::*; (
	input  wire logic    clk,
	input  wire logic    en,
	input  wire cordic_t d,
	input  wire side_t   sd,
	output result_t      q
);
	logic signed [CW-1:0] c, s;
	always_comb begin
		unique case (sd.quad)
			2'd0: begin c = d.x;  s = d.y;  end
			2'd1: begin c = -d.y; s = d.x;  end
			2'd2: begin c = -d.x; s = -d.y; end
			default: begin c = d.y; s = -d.x; end
		endcase
	end

	// stage 1: products
	logic signed [66:0] pl_c_s1, pr_c_s1, pb_s_s1, pt_s_s1;
	logic signed [66:0] pl_s_s1, pr_s_s1, pb_c_s1, pt_c_s1;
	side_t sd_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			pl_c_s1 <= 67'(sd.left * c);   pr_c_s1 <= 67'(sd.right * c);
			pb_s_s1 <= 67'(sd.bottom * s); pt_s_s1 <= 67'(sd.top * s);
			pl_s_s1 <= 67'(sd.left * s);   pr_s_s1 <= 67'(sd.right * s);
			pb_c_s1 <= 67'(sd.bottom * c); pt_c_s1 <= 67'(sd.top * c);
			sd_s1 <= sd;
		end
	end

	function automatic logic signed [31:0] comp(input logic signed [66:0] p,
			input logic signed [31:0] t);
		logic signed [66:0] r;
		r = (p + 67'sd536870912) >>> 30;
		return sat32(36'(r) + 36'(t));
	endfunction

	// stage 2: corners
	logic signed [31:0] cx_s2 [4];
	logic signed [31:0] cy_s2 [4];
	logic circle_s2;
	logic signed [31:0] px_s2, py_s2;
	logic [30:0] r_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2[0] <= comp(pl_c_s1 - pt_s_s1, sd_s1.px);
			cy_s2[0] <= comp(pl_s_s1 + pt_c_s1, sd_s1.py);
			cx_s2[1] <= comp(pr_c_s1 - pt_s_s1, sd_s1.px);
			cy_s2[1] <= comp(pr_s_s1 + pt_c_s1, sd_s1.py);
			cx_s2[2] <= comp(pr_c_s1 - pb_s_s1, sd_s1.px);
			cy_s2[2] <= comp(pr_s_s1 + pb_c_s1, sd_s1.py);
			cx_s2[3] <= comp(pl_c_s1 - pb_s_s1, sd_s1.px);
			cy_s2[3] <= comp(pl_s_s1 + pb_c_s1, sd_s1.py);
			circle_s2 <= sd_s1.circle;
			px_s2 <= sd_s1.px; py_s2 <= sd_s1.py; r_s2 <= sd_s1.radius;
		end
	end

	function automatic logic signed [31:0] mn(input logic signed [31:0] a, b);
		return (b < a) ? b : a;
	endfunction
	function automatic logic signed [31:0] mx(input logic signed [31:0] a, b);
		return (b > a) ? b : a;
	endfunction

	// stage 3: bounds
	logic signed [35:0] rr;
	assign rr = 36'($signed({1'b0, r_s2}));
	always_ff @(posedge clk) begin
		if (en) begin
			if (circle_s2) begin
				q.c0x <= '0; q.c0y <= '0; q.c1x <= '0; q.c1y <= '0;
				q.c2x <= '0; q.c2y <= '0; q.c3x <= '0; q.c3y <= '0;
				q.min_x <= sat32(36'(px_s2) - rr);
				q.min_y <= sat32(36'(py_s2) - rr);
				q.max_x <= sat32(36'(px_s2) + rr);
				q.max_y <= sat32(36'(py_s2) + rr);
			end else begin
				q.c0x <= cx_s2[0]; q.c0y <= cy_s2[0]; q.c1x <= cx_s2[1]; q.c1y <= cy_s2[1];
				q.c2x <= cx_s2[2]; q.c2y <= cy_s2[2]; q.c3x <= cx_s2[3]; q.c3y <= cy_s2[3];
				q.min_x <= mn(mn(cx_s2[0], cx_s2[1]), mn(cx_s2[2], cx_s2[3]));
				q.min_y <= mn(mn(cy_s2[0], cy_s2[1]), mn(cy_s2[2], cy_s2[3]));
				q.max_x <= mx(mx(cx_s2[0], cx_s2[1]), mx(cx_s2[2], cx_s2[3]));
				q.max_y <= mx(mx(cy_s2[0], cy_s2[1]), mx(cy_s2[2], cy_s2[3]));
			end
		end
	end
endmodule
`default_nettype wire

### dv/obb_checker.sv
// ----------------------------------------------------------------------------
// obb_checker
// Watches the input, result and register channels of the box bounds core,
// computes the expected corners and bounds of every accepted body and
// compares them field by field with the result beats in order.
// ----------------------------------------------------------------------------
module obb_checker import obb_pkg::*; (
	input logic clk,
	input logic arst_n,
	obb_in_if.source  in_ch,
	obb_out_if.sink   out_ch,
	obb_cfg_if.source cfg,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic        mode_q;
	logic [30:0] width_q, height_q, radius_q;
	result_t     bounds_q[$];
	int          seen;

	localparam int NUM_ATAN = 30;
	localparam longint ATAN[NUM_ATAN] = '{
		'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
		'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
		'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
		'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
		'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void sin_cos(logic [15:0] ang, output longint c, output longint s);
		logic [31:0] phase;
		logic [1:0]  quad;
		longint x, y, z, dx, dy;
		phase = {ang, 16'h0};
		quad = 2'((phase + 32'h20000000) >> 30);
		z = longint'(phase) - longint'(quad) * 64'sh40000000;
		x = 652032874;
		y = 0;
		if (z >= 64'sh80000000) z -= 64'sh100000000;
		for (int i = 0; i < NUM_ATAN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic result_t body_bounds(longint px, longint py, logic [15:0] ang);
		result_t r;
		longint w, h, lft, bot, c, s, tx, ty, rad;
		longint vx[4], vy[4], cx[4], cy[4], mnx, mny, mxx, mxy;
		r = '0;
		if (mode_q) begin
			rad = radius_q;
			r.min_x = 32'(clip32(px - rad));
			r.min_y = 32'(clip32(py - rad));
			r.max_x = 32'(clip32(px + rad));
			r.max_y = 32'(clip32(py + rad));
			return r;
		end
		w = (width_q < 31'h10000) ? 64'h10000 : longint'(width_q);
		h = (height_q < 31'h10000) ? 64'h10000 : longint'(height_q);
		lft = -(w >>> 1);
		bot = -(h >>> 1);
		vx = '{lft, lft + w, lft + w, lft};
		vy = '{bot + h, bot + h, bot, bot};
		sin_cos(ang, c, s);
		for (int k = 0; k < 4; k++) begin
			tx = clip32(((vx[k] * c - vy[k] * s + (64'sd1 <<< 29)) >>> 30) + px);
			ty = clip32(((vx[k] * s + vy[k] * c + (64'sd1 <<< 29)) >>> 30) + py);
			cx[k] = tx;
			cy[k] = ty;
			if (k == 0 || tx < mnx) mnx = tx;
			if (k == 0 || ty < mny) mny = ty;
			if (k == 0 || tx > mxx) mxx = tx;
			if (k == 0 || ty > mxy) mxy = ty;
		end
		r.c0x = 32'(cx[0]); r.c0y = 32'(cy[0]); r.c1x = 32'(cx[1]); r.c1y = 32'(cy[1]);
		r.c2x = 32'(cx[2]); r.c2y = 32'(cy[2]); r.c3x = 32'(cx[3]); r.c3y = 32'(cy[3]);
		r.min_x = 32'(mnx); r.min_y = 32'(mny); r.max_x = 32'(mxx); r.max_y = 32'(mxy);
		return r;
	endfunction

	function automatic void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t beat %0d %s expected %h actual %h", $realtime, seen, name,
				exp_v, act_v);
		end
	endfunction

	assign pending = bounds_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			mode_q <= 1'b0;
			width_q <= 31'h10000;
			height_q <= 31'h10000;
			radius_q <= 31'h10000;
			bounds_q.delete();
			errors = 0;
			seen = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MODE:   mode_q <= cfg.data[0];
					REG_WIDTH:  width_q <= cfg.data[30:0];
					REG_HEIGHT: height_q <= cfg.data[30:0];
					REG_RADIUS: radius_q <= cfg.data[30:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				bounds_q.push_back(body_bounds(in_ch.pos_x, in_ch.pos_y, in_ch.angle));
			if (out_ch.valid && out_ch.ready) begin
				seen++;
				if (bounds_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result beat", $realtime);
				end else begin
					e = bounds_q.pop_front();
					compare("corner0_x", e.c0x, out_ch.corner0_x);
					compare("corner0_y", e.c0y, out_ch.corner0_y);
					compare("corner1_x", e.c1x, out_ch.corner1_x);
					compare("corner1_y", e.c1y, out_ch.corner1_y);
					compare("corner2_x", e.c2x, out_ch.corner2_x);
					compare("corner2_y", e.c2y, out_ch.corner2_y);
					compare("corner3_x", e.c3x, out_ch.corner3_x);
					compare("corner3_y", e.c3y, out_ch.corner3_y);
					compare("min_x", e.min_x, out_ch.min_x);
					compare("min_y", e.min_y, out_ch.min_y);
					compare("max_x", e.max_x, out_ch.max_x);
					compare("max_y", e.max_y, out_ch.max_y);
				end
			end
		end
	end
endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives bodies and register writes into the box bounds core with random
// gaps and result back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
	import obb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	int   errors, pending, cycles, bodies;
	bit   quiet;

	obb_in_if  in_ch();
	obb_out_if out_ch();
	obb_cfg_if cfg();

	oriented_box_bounds_core DUT (.clk, .arst_n, .in_ch, .out_ch, .cfg);
	obb_checker chk (.clk, .arst_n, .in_ch, .out_ch, .cfg, .errors, .pending);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("oriented_box_bounds_core: mismatch");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		int n;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = quiet ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 3) == 0) n = 0;
			@(negedge clk);
			if (n != 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// called at a falling edge; leaves valid high so a zero gap gives back-to-back beats
	task automatic send_body(logic [31:0] px, logic [31:0] py, logic [15:0] ang);
		int n;
		n = quiet ? 0 : $urandom_range(0, 13);
		if (n != 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pos_x <= px;
		in_ch.pos_y <= py;
		in_ch.angle <= ang;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		bodies++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_size();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 'hFFFF);
			1: return 32'h7FFFFFFF;
			2: return $urandom;
			default: return $urandom_range('h10000, 'h400000);
		endcase
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFFF000 + $urandom_range(0, 'hFFF)
				: 32'h80000000 + $urandom_range(0, 'hFFF);
			default: return $signed($urandom_range(0, 'h1FFFFFF)) - 'h1000000;
		endcase
	endfunction

	initial begin
		logic [15:0] dir_ang[8] = '{16'h0000, 16'h2000, 16'h4000, 16'h6000,
			16'h8000, 16'hC000, 16'hFFFF, 16'h1FFF};
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.angle = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_MODE;
		cfg.data = '0;
		cycles = 0;
		bodies = 0;
		quiet = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, angle sweep, extreme positions
		foreach (dir_ang[i]) send_body($urandom, $urandom, dir_ang[i]);
		send_body(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h1000);
		send_body(32'h80000000, 32'h80000000, 16'h9000);
		send_body(32'h0, 32'h0, 16'h0);
		drain();
		write_reg(REG_WIDTH, 32'h7FFFFFFF);
		write_reg(REG_HEIGHT, 32'h0);
		for (int i = 0; i < 4; i++)
			send_body(32'h7FFFFFFF - i, 32'h80000000, 16'(i * 'h4000));
		drain();
		write_reg(REG_HEIGHT, 32'hFFFFFFFF);
		write_reg(REG_WIDTH, 32'h0000FFFF);
		send_body(32'h80000000, 32'h7FFFFFFF, 16'h2000);
		send_body(32'h0, 32'h0, 16'hE000);
		drain();
		write_reg(REG_MODE, 32'hFFFFFFFE);
		write_reg(REG_MODE, 32'h1);
		write_reg(REG_RADIUS, 32'hFFFFFFFF);
		send_body(32'h7FFFFFFF, 32'h80000000, 16'hFFFF);
		send_body(32'h80000000, 32'h7FFFFFFF, 16'h0);
		drain();
		write_reg(REG_RADIUS, 32'h0);
		send_body(32'h12345678, 32'hEDCBA987, 16'h5555);
		drain();

		for (int ph = 0; ph < 28; ph++) begin
			write_reg(REG_MODE, (ph % 4 == 3) ? {$urandom} | 1 : {$urandom} & ~1);
			write_reg(REG_WIDTH, rand_size());
			write_reg(REG_HEIGHT, rand_size());
			write_reg(REG_RADIUS, rand_size());
			quiet = (ph % 5 == 2);
			for (int i = 0; i < 40; i++) send_body(rand_pos(), rand_pos(), 16'($urandom));
			drain();
			quiet = 0;
		end

		$display("%0d bodies in box and circle modes over random sizes, angles and positions",
			bodies);
		if (errors == 0)
			$display("oriented_box_bounds_core: match");
		else
			$display("oriented_box_bounds_core: mismatch");
		$finish;
	end
endmodule

### files.f
rtl/obb_pkg.sv
rtl/obb_if.sv
rtl/obb_cordic_cell.sv
rtl/obb_corner.sv
rtl/oriented_box_bounds_core.sv
dv/obb_checker.sv
dv/tb.sv
